FILE: rtl/core/rapt_pkg.sv
// Shared types and constants for the RTC alarm and periodic timer.
package rapt_pkg;

	// Operation codes carried in a request
	localparam logic [1:0] FUNC_TICK  = 2'd0;
	localparam logic [1:0] FUNC_READ  = 2'd1;
	localparam logic [1:0] FUNC_WRITE = 2'd2;
	localparam logic [1:0] FUNC_NOP   = 2'd3;

	// Register offsets
	localparam logic [2:0] REG_RTC_HI   = 3'd0;
	localparam logic [2:0] REG_RTC_LO   = 3'd1;
	localparam logic [2:0] REG_ALARM_HI = 3'd2;
	localparam logic [2:0] REG_ALARM_LO = 3'd3;
	localparam logic [2:0] REG_CONTROL  = 3'd4;
	localparam logic [2:0] REG_PERIODIC = 3'd5;

	// Control word bit positions
	localparam int CTRL_CLEAR_BIT  = 2;
	localparam int CTRL_PER_EN_BIT = 4;
	localparam int CTRL_FREEZE_BIT = 6;

	// Upper alarm / counter half: 11 bits from bit 32 up
	localparam int                  HI_W    = 11;
	localparam int                  HI_LSB  = 32;
	localparam int                  ALARM_W = HI_LSB + HI_W;
	localparam logic [HI_W-1:0]     HI_MASK = 11'h7FF;

	typedef struct packed {
		logic [1:0]  func;
		logic [2:0]  reg_sel;
		logic [31:0] write_data;
		logic        alarm_pending;
	} rapt_req_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        decoded;
		logic        alarm_irq;
		logic        periodic_irq;
	} rapt_rsp_t;

	typedef enum logic [1:0] {
		SEQ_IDLE,
		SEQ_LOAD,
		SEQ_DIV,
		SEQ_FIN
	} rapt_seq_t;

endpackage

FILE: rtl/core/rapt_div.sv
// Iterative restoring divider, one quotient bit per cycle.
module rapt_div import rapt_pkg::*; #(
	parameter int DIVIDEND_W = 43,
	parameter int DIVISOR_W  = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [DIVISOR_W-1:0]  divisor,
	output logic                  done,
	output logic [DIVIDEND_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DIVIDEND_W + 1);

	logic                  busy_q;
	logic                  done_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [DIVIDEND_W-1:0] quo_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W-1:0]  dvs_q;

	logic [DIVISOR_W:0] trial;
	logic [DIVISOR_W:0] diff;
	logic               ge;

	// Shared subtract/compare step
	always_comb begin
		trial = {rem_q, quo_q[DIVIDEND_W-1]};
		diff  = trial - {1'b0, dvs_q};
		ge    = trial >= {1'b0, dvs_q};
	end

	// Step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIVIDEND_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Datapath: dividend shifts out, quotient bits shift in
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIVIDEND_W-2:0], ge};
			rem_q <= ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

FILE: rtl/core/rtc_alarm_periodic_timer.sv
// Top level: RTC counter, alarm and periodic interrupt with bus registers.
//
//  channel | handshake              | payload
//  --------+------------------------+---------------------------------------
//  request | req_valid / req_ready  | req  (func, reg_sel, write_data, pend)
//  result  | rsp_valid / rsp_ready  | rsp  (read_data, decoded, irqs)
//
// Reads, writes, no-ops and ticks while frozen load the result register
// when accepted. An unfrozen tick steps through LOAD, DIV and FIN, where
// the bit-serial divider forms counter / reload for the period index;
// with a zero reload the divider is skipped and LOAD goes straight to FIN.
// The block takes one request at a time; it is ready when idle and the
// result register is empty or being drained in the same cycle.
// Reset clears all but rsp_q and divider datapath; no clearing pass needed.
module rtc_alarm_periodic_timer import rapt_pkg::*; #(
	parameter int RTC_WIDTH    = 43,
	parameter int RELOAD_WIDTH = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  rapt_req_t req,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output rapt_rsp_t rsp
);

	localparam int EXT_W = (RTC_WIDTH > ALARM_W) ? RTC_WIDTH : ALARM_W;

	rapt_seq_t state_q, state_d;

	logic [RTC_WIDTH-1:0]    rtc_q;
	logic [HI_W-1:0]         alm_upper_q;
	logic [31:0]             alm_lower_q;
	logic [31:0]             control_q;
	logic [31:0]             periodic_q;
	logic [RELOAD_WIDTH-1:0] reload_q;
	logic [RTC_WIDTH-1:0]    period_idx_q;
	logic                    pend_q;
	rapt_rsp_t               rsp_q;
	logic                    rsp_valid_q;

	logic                    accept;
	logic                    tick_slow;
	logic                    reload_zero;
	logic                    div_start;
	logic                    div_done;
	logic [RTC_WIDTH-1:0]    quotient;
	logic [EXT_W-1:0]        rtc_ext;
	logic [ALARM_W-1:0]      alarm_val;
	logic                    alarm_hit;
	logic                    per_en;
	logic                    per_fire;
	rapt_rsp_t               imm_rsp;
	rapt_rsp_t               fin_rsp;

	assign accept      = req_valid && req_ready;
	assign tick_slow   = (req.func == FUNC_TICK) && !control_q[CTRL_FREEZE_BIT];
	assign reload_zero = (reload_q == '0);
	assign rtc_ext     = EXT_W'(rtc_q);
	assign alarm_val   = {alm_upper_q, alm_lower_q};
	assign per_en      = control_q[CTRL_PER_EN_BIT];

	// Period index divider
	rapt_div #(
		.DIVIDEND_W(RTC_WIDTH),
		.DIVISOR_W (RELOAD_WIDTH)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(rtc_q),
		.divisor (reload_q),
		.done    (div_done),
		.quotient(quotient)
	);

	// Sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SEQ_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequencer next state and controls
	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		div_start = 1'b0;
		case (state_q)
			SEQ_IDLE: begin
				req_ready = !rsp_valid_q || rsp_ready;
				if (req_valid && req_ready && tick_slow) begin
					state_d = SEQ_LOAD;
				end
			end
			SEQ_LOAD: begin
				div_start = !reload_zero;
				state_d   = reload_zero ? SEQ_FIN : SEQ_DIV;
			end
			SEQ_DIV: begin
				if (div_done) begin
					state_d = SEQ_FIN;
				end
			end
			SEQ_FIN: begin
				state_d = SEQ_IDLE;
			end
			default: begin
				state_d = SEQ_IDLE;
			end
		endcase
	end

	// Immediate result: reads, writes, no-ops, frozen ticks
	always_comb begin
		imm_rsp = '0;
		case (req.func)
			FUNC_READ: begin
				imm_rsp.decoded = 1'b1;
				case (req.reg_sel)
					REG_RTC_HI:   imm_rsp.read_data = 32'(rtc_ext[HI_LSB +: HI_W]);
					REG_RTC_LO:   imm_rsp.read_data = rtc_q[31:0];
					REG_ALARM_HI: imm_rsp.read_data = 32'(alm_upper_q);
					REG_ALARM_LO: imm_rsp.read_data = alm_lower_q;
					REG_CONTROL:  imm_rsp.read_data = control_q;
					REG_PERIODIC: imm_rsp.read_data = periodic_q;
					default:      imm_rsp.decoded   = 1'b0;
				endcase
			end
			FUNC_WRITE: begin
				imm_rsp.decoded = (req.reg_sel <= REG_PERIODIC);
			end
			default: begin
				imm_rsp = '0;
			end
		endcase
	end

	// Tick checks, done after the counter has advanced
	always_comb begin
		alarm_hit = (alarm_val != '0) && (rtc_ext >= EXT_W'(alarm_val)) && !pend_q;
		per_fire  = per_en && !reload_zero && (quotient != period_idx_q);
		fin_rsp              = '0;
		fin_rsp.alarm_irq    = alarm_hit;
		fin_rsp.periodic_irq = per_fire;
	end

	// Counter, bus registers and period index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rtc_q        <= '0;
			alm_upper_q  <= '0;
			alm_lower_q  <= '0;
			control_q    <= '0;
			periodic_q   <= '0;
			reload_q     <= '0;
			period_idx_q <= '0;
			pend_q       <= 1'b0;
		end else begin
			if (accept) begin
				pend_q <= req.alarm_pending;
				case (req.func)
					FUNC_TICK: begin
						rtc_q <= rtc_q + RTC_WIDTH'(1);
					end
					FUNC_WRITE: begin
						case (req.reg_sel)
							REG_ALARM_HI: alm_upper_q <= req.write_data[HI_W-1:0] & HI_MASK;
							REG_ALARM_LO: alm_lower_q <= req.write_data;
							REG_CONTROL: begin
								control_q <= req.write_data;
								if (req.write_data[CTRL_CLEAR_BIT]) begin
									rtc_q <= '0;
								end
							end
							REG_PERIODIC: begin
								periodic_q <= req.write_data;
								reload_q   <= req.write_data[RELOAD_WIDTH-1:0];
							end
							default: begin
							end
						endcase
					end
					default: begin
					end
				endcase
			end
			// Period index update on an unfrozen tick
			if (state_q == SEQ_FIN) begin
				period_idx_q <= reload_zero ? '0 : quotient;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if ((accept && !tick_slow) || (state_q == SEQ_FIN)) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !tick_slow) begin
			rsp_q <= imm_rsp;
		end else if (state_q == SEQ_FIN) begin
			rsp_q <= fin_rsp;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
